// File: rtl/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) cond) \
    else $error("assertion failed");

// signal must hold while a condition is true on the previous edge
`define ASSERT_HOLD(label, clk, rst_n, pre, sig) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> $stable(sig)) \
    else $error("signal changed while held");

`endif

// File: rtl/rptw_pkg.sv
// ----------------------------------------------------------------------------
// rptw_pkg
// types and constants shared by the page-table walker modules
// ----------------------------------------------------------------------------
package rptw_pkg;

  localparam int unsigned IdxW   = 9;
  localparam int unsigned AddrW  = 52;
  localparam int unsigned VaW    = 48;
  localparam int unsigned DataW  = 64;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [2:0] OP_RESOLVE_ADDR = 3'd0;
  localparam logic [2:0] OP_RESOLVE_PERM = 3'd1;
  localparam logic [2:0] OP_MAP          = 3'd2;
  localparam logic [2:0] OP_UNMAP        = 3'd3;
  localparam logic [2:0] OP_SET_PERM     = 3'd4;
  localparam logic [2:0] OP_REMAP        = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ABSENT    = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_BADPTR    = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_ADDR_MASK  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PERM_MASK  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESENT    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TABLE_FLAGS = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LARGE_FLAG = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_REGION_BASE = 3'd5;

  typedef struct packed {
    logic [2:0]       operation;
    logic             large_page;
    logic [VaW-1:0]   virtual_address;
    logic [AddrW-1:0] physical_address;
    logic [DataW-1:0] entry_flags;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] result_address;
    logic [DataW-1:0] result_permissions;
  } rsp_t;

  typedef struct packed {
    logic [DataW-1:0] address_mask;
    logic [DataW-1:0] permission_mask;
    logic [DataW-1:0] present_bit_mask;
    logic [DataW-1:0] table_entry_flags;
    logic [DataW-1:0] large_page_flag;
    logic [AddrW-1:0] table_region_base;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic       load_req;   // capture request, reset walk frame to root
    logic       clr_en;     // clearing pass write
    logic       rd_en;      // read entry at current level
    logic [1:0] level;      // 0 = top index
    logic       eval;       // evaluate registered entry
    logic       leaf_wr;    // write leaf
    logic       rsp_load;   // load result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       clr_done;
    logic       present;
    logic       badptr;
    logic       exhausted;
  } sts_t;

endpackage

// File: rtl/rptw_datapath.sv
// ----------------------------------------------------------------------------
// rptw_datapath
// table store, allocator, walk frame register and result formation
// ----------------------------------------------------------------------------
module rptw_datapath import rptw_pkg::*; #(
  parameter int unsigned TableFrames = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  req_t req_i,
  input  cmd_t cmd_i,
  input  logic [1:0] rsp_status_i,
  output sts_t sts_o,
  output rsp_t rsp_o
);

  localparam int unsigned FrameW = (TableFrames > 1) ? $clog2(TableFrames) : 1;
  localparam int unsigned CntW   = $clog2(TableFrames + 1);
  localparam int unsigned MemAw  = FrameW + IdxW;
  localparam int unsigned Depth  = TableFrames * 512;

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;
  logic [MemAw-1:0] clr_q, clr_d;
  logic [CntW-1:0]  nff_q, nff_d;
  logic [FrameW-1:0] frame_q, frame_d;
  req_t req_q;
  rsp_t rsp_q, rsp_d;

  logic [IdxW-1:0]  idx;
  logic [MemAw-1:0] addr;
  logic             we;
  logic [DataW-1:0] wdata;
  logic [DataW-1:0] ptr;
  logic [AddrW:0]   off;
  logic             ptr_ok;
  logic [AddrW-1:0] naddr;
  logic             is_res;
  logic [DataW-1:0] leaf_new;
  logic [DataW-1:0] extra;

  always_comb begin
    unique case (cmd_i.level)
      2'd0:    idx = req_q.virtual_address[47:39];
      2'd1:    idx = req_q.virtual_address[38:30];
      2'd2:    idx = req_q.virtual_address[29:21];
      default: idx = req_q.virtual_address[20:12];
    endcase
  end

  assign addr = cmd_i.clr_en ? clr_q : {frame_q, idx};
  assign is_res = (req_q.operation == OP_RESOLVE_ADDR) || (req_q.operation == OP_RESOLVE_PERM);

  // walk pointer check
  assign ptr = rdata_q & cfg_i.address_mask;
  assign off = {1'b0, ptr[AddrW-1:0]} - {1'b0, cfg_i.table_region_base};
  assign ptr_ok = (ptr[DataW-1:AddrW] == '0) && !off[AddrW]
                  && (off[AddrW-1:12] < (AddrW-12)'(TableFrames));
  assign naddr = cfg_i.table_region_base + {{(AddrW-12-CntW){1'b0}}, nff_q, 12'h000};

  assign extra = req_q.large_page ? cfg_i.large_page_flag : '0;
  always_comb begin
    unique case (req_q.operation)
      OP_UNMAP:    leaf_new = '0;
      OP_SET_PERM: leaf_new = (rdata_q & cfg_i.address_mask) | req_q.entry_flags | extra;
      default:     leaf_new = {12'h000, req_q.physical_address} | req_q.entry_flags | extra;
    endcase
  end

  // writes: clearing, new intermediate entry, leaf
  logic alloc;
  assign alloc = cmd_i.eval && !(|(rdata_q & cfg_i.present_bit_mask))
                 && (req_q.operation == OP_MAP) && (nff_q < CntW'(TableFrames));
  always_comb begin
    we = 1'b0;
    wdata = '0;
    if (cmd_i.clr_en) begin
      we = 1'b1;
    end else if (alloc) begin
      we = 1'b1;
      wdata = {12'h000, naddr} | cfg_i.table_entry_flags;
    end else if (cmd_i.leaf_wr) begin
      we = 1'b1;
      wdata = leaf_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
  end

  always_comb begin
    clr_d = clr_q;
    nff_d = nff_q;
    frame_d = frame_q;
    if (cmd_i.clr_en) begin
      clr_d = clr_q + 1'b1;
    end
    if (cmd_i.load_req) begin
      frame_d = '0;
    end else if (alloc) begin
      frame_d = nff_q[FrameW-1:0];
      nff_d = nff_q + 1'b1;
    end else if (cmd_i.eval && ptr_ok) begin
      frame_d = off[FrameW+11:12];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      nff_q <= CntW'(1);
      frame_q <= '0;
    end else begin
      clr_q <= clr_d;
      nff_q <= nff_d;
      frame_q <= frame_d;
    end
  end

  always_comb begin
    rsp_d.status = rsp_status_i;
    rsp_d.result_address = is_res ? '0 : {4'h0, req_q.virtual_address};
    rsp_d.result_permissions = '0;
    if (rsp_status_i == ST_OK && req_q.operation <= OP_REMAP) begin
      if (is_res) begin
        rsp_d.result_address = ptr[AddrW-1:0];
        rsp_d.result_permissions = rdata_q & cfg_i.permission_mask;
      end else begin
        rsp_d.result_permissions = leaf_new & cfg_i.permission_mask;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;
  assign sts_o.clr_done = (clr_q == MemAw'(Depth - 1));
  assign sts_o.present = |(rdata_q & cfg_i.present_bit_mask);
  assign sts_o.badptr = !ptr_ok;
  assign sts_o.exhausted = !(nff_q < CntW'(TableFrames));

endmodule

// File: rtl/rptw_ctrl.sv
// ----------------------------------------------------------------------------
// rptw_ctrl
// sequencer for clearing, walk, leaf access and result handshake
// ----------------------------------------------------------------------------
module rptw_ctrl import rptw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  logic [2:0] op_i,
  input  logic large_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic [1:0] status_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_LEAF  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] level_q, level_d;
  logic [2:0] op_q, op_d;
  logic       large_q, large_d;
  logic [1:0] st_q, st_d;
  logic       vld_q, vld_d;
  logic [1:0] leaf_lvl;

  assign leaf_lvl = large_q ? 2'd2 : 2'd3;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = vld_q;
  assign status_o = st_q;

  always_comb begin
    state_d = state_q;
    level_d = level_q;
    op_d = op_q;
    large_d = large_q;
    st_d = st_q;
    vld_d = vld_q && out_stall_i;
    cmd_o = '0;
    cmd_o.level = level_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          op_d = op_i;
          large_d = large_i;
          level_d = 2'd0;
          st_d = ST_OK;
          state_d = (op_i <= OP_REMAP) ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = (level_q == leaf_lvl) ? S_LEAF : S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        level_d = level_q + 2'd1;
        state_d = S_READ;
        if (sts_i.present) begin
          if (sts_i.badptr) begin
            st_d = ST_BADPTR;
            state_d = S_DONE;
          end
        end else if (op_q == OP_MAP) begin
          if (sts_i.exhausted) begin
            st_d = ST_EXHAUSTED;
            state_d = S_DONE;
          end
        end else begin
          st_d = ST_ABSENT;
          state_d = S_DONE;
        end
      end
      S_LEAF: begin
        cmd_o.leaf_wr = (op_q != OP_RESOLVE_ADDR) && (op_q != OP_RESOLVE_PERM);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!vld_q || !out_stall_i) begin
          cmd_o.rsp_load = 1'b1;
          vld_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      level_q <= '0;
      op_q <= '0;
      large_q <= 1'b0;
      st_q <= ST_OK;
      vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      op_q <= op_d;
      large_q <= large_d;
      st_q <= st_d;
      vld_q <= vld_d;
    end
  end

endmodule

// File: rtl/radix_page_table_walker_core.sv
// ----------------------------------------------------------------------------
// radix_page_table_walker_core
// four-level radix page-table engine over an on-chip table store
// ----------------------------------------------------------------------------
// requests enter on req_valid_i/req_stall_o carrying one req_t; one result
// leaves per request on rsp_valid_o/rsp_stall_i as an rsp_t.
// a request walks the table store one level at a time: a read and an evaluate
// step per intermediate level, then a leaf read, a leaf write (not for
// resolves) and the result load. a 2 MiB request has its leaf one level
// above a 4 KiB one; a failing level stops the walk early. one request at
// a time: req_stall_o is high unless idle. after reset the store is cleared
// one entry per cycle while req_stall_o stays high; configuration writes are
// taken. a stalled result is held in the output register; the next request
// may be accepted meanwhile and waits for the register before its result
// loads. configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i
// while idle; the user must keep to this, the block does not enforce it.
// ----------------------------------------------------------------------------
module radix_page_table_walker_core import rptw_pkg::*; #(
  parameter int unsigned TableFrames = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_stall_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_stall_i,
  output rsp_t rsp_o,
  input  logic cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0] cfg_data_i
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic [1:0] status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.address_mask <= 64'h000F_FFFF_FFFF_F000;
      cfg_q.permission_mask <= 64'hFFF0_0000_0000_0FFF;
      cfg_q.present_bit_mask <= 64'd1;
      cfg_q.table_entry_flags <= 64'd7;
      cfg_q.large_page_flag <= 64'h80;
      cfg_q.table_region_base <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ADDR_MASK:   cfg_q.address_mask <= cfg_data_i;
        CFG_PERM_MASK:   cfg_q.permission_mask <= cfg_data_i;
        CFG_PRESENT:     cfg_q.present_bit_mask <= cfg_data_i;
        CFG_TABLE_FLAGS: cfg_q.table_entry_flags <= cfg_data_i;
        CFG_LARGE_FLAG:  cfg_q.large_page_flag <= cfg_data_i;
        CFG_REGION_BASE: cfg_q.table_region_base <= cfg_data_i[AddrW-1:0];
        default: ;
      endcase
    end
  end

  rptw_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i(req_valid_i),
    .in_stall_o(req_stall_o),
    .out_valid_o(rsp_valid_o),
    .out_stall_i(rsp_stall_i),
    .op_i(req_i.operation),
    .large_i(req_i.large_page),
    .sts_i(sts),
    .cmd_o(cmd),
    .status_o(status)
  );

  rptw_datapath #(.TableFrames(TableFrames)) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_i(cfg_q),
    .req_i,
    .cmd_i(cmd),
    .rsp_status_i(status),
    .sts_o(sts),
    .rsp_o
  );

endmodule

// File: rtl/rptw_checker.sv
// ----------------------------------------------------------------------------
// rptw_checker
// port-level checks on the walker, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rptw_checker import rptw_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_stall_o,
  input logic rsp_valid_o,
  input logic rsp_stall_i,
  input rsp_t rsp_o
);

  // req_stall_o is high in the cycle after a transfer in, so transfers never come back to back
  `ASSERT_IMPL(a_one_at_a_time, clk_i, rst_ni, (req_valid_i && !req_stall_o) |=> req_stall_o)
  // a stalled result holds
  `ASSERT_HOLD(a_rsp_hold, clk_i, rst_ni, (rsp_valid_o && rsp_stall_i), rsp_o)
  // a failed request carries no permissions
  `ASSERT_IMPL(a_fail_noperm, clk_i, rst_ni,
               (rsp_valid_o && rsp_o.status != ST_OK) |-> (rsp_o.result_permissions == '0))
  // with no result pending, no result appears in the cycle after a request transfer
  `ASSERT_IMPL(a_no_instant, clk_i, rst_ni,
               (req_valid_i && !req_stall_o && !rsp_valid_o) |=> !rsp_valid_o)

endmodule

bind radix_page_table_walker_core rptw_checker u_rptw_checker (.*);
